// File: design/scwp_pkg.sv
// Shared constants, types and store access structs for the wavelet power core.
// No dependencies; every other file of the block depends on this package.
package scwp_pkg;

  localparam int MAX_HALF    = 255;
  localparam int SAMPLE_BITS = 16;

  localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
  localparam int COUNT_SAT = WIN_DEPTH + 1;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int HALF_W    = $clog2(MAX_HALF + 1);
  localparam int CNT_W     = $clog2(COUNT_SAT + 1);

  localparam int HALF_LEN_W = 8;
  localparam int COEF_W     = 16;
  localparam int IDX_W      = 8;
  localparam int POWER_W    = 63;

  localparam int MUL_W = 32;
  localparam int PROD_W = 2 * MUL_W;
  // Product of a pair sum and a coefficient, grown by the number of terms.
  localparam int ACC_W = SAMPLE_BITS + 1 + COEF_W + HALF_W + 1;

  localparam logic [HALF_LEN_W-1:0] HALF_LEN_RESET = HALF_LEN_W'(16);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]      coef_t;

  typedef struct packed {
    logic              win_we;
    logic [WIN_AW-1:0] win_addr;
    sample_t           sample;
    logic              coef_we;
    logic [HALF_W-1:0] coef_addr;
    coef_t             re;
    coef_t             im;
  } store_wr_t;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr_l;
    logic [WIN_AW-1:0] addr_r;
    logic [HALF_W-1:0] coef_addr;
  } store_rd_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
    coef_t   re;
    coef_t   im;
  } store_data_t;

endpackage

// File: design/scwp_if.sv
// Valid/ready channel interfaces for sample and coefficient requests and power results.
// Depends on scwp_pkg for field widths.
interface scwp_item_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [scwp_pkg::IDX_W-1:0]       coef_index;
  logic signed [scwp_pkg::COEF_W-1:0] coef_real;
  logic signed [scwp_pkg::COEF_W-1:0] coef_imag;
  logic signed [15:0]               sample_value;
  logic                             last;

  modport source (output valid, op, coef_index, coef_real, coef_imag, sample_value, last,
                  input ready);
  modport sink (input valid, op, coef_index, coef_real, coef_imag, sample_value, last,
                output ready);
endinterface

interface scwp_result_if;
  logic                         valid;
  logic                         ready;
  logic [scwp_pkg::POWER_W-1:0] power;
  logic                         window_error;

  modport source (output valid, power, window_error, input ready);
  modport sink (input valid, power, window_error, output ready);
endinterface

// File: design/scwp_mul.sv
// Shared signed 32 x 32 multiplier with a registered product.
// Depends on scwp_pkg for operand widths.
module scwp_mul (
  input  logic                                 clk,
  input  logic signed [scwp_pkg::MUL_W-1:0]    a,
  input  logic signed [scwp_pkg::MUL_W-1:0]    b,
  output logic signed [scwp_pkg::PROD_W-1:0]   prod
);
  import scwp_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: design/scwp_store.sv
// Window sample memory (two read ports) and the real and imaginary coefficient tables.
// Depends on scwp_pkg for sizes and the access structs.
module scwp_store (
  input  logic                  clk,
  input  scwp_pkg::store_wr_t   wr,
  input  scwp_pkg::store_rd_t   rd,
  output scwp_pkg::store_data_t rdata
);
  import scwp_pkg::*;

  sample_t win_mem [WIN_DEPTH];
  coef_t   re_mem  [MAX_HALF+1];
  coef_t   im_mem  [MAX_HALF+1];

  always_ff @(posedge clk) begin
    if (wr.win_we) begin
      win_mem[wr.win_addr] <= wr.sample;
    end
    if (wr.coef_we) begin
      re_mem[wr.coef_addr] <= wr.re;
      im_mem[wr.coef_addr] <= wr.im;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata.left  <= win_mem[rd.addr_l];
      rdata.right <= win_mem[rd.addr_r];
      rdata.re    <= re_mem[rd.coef_addr];
      rdata.im    <= im_mem[rd.coef_addr];
    end
  end

endmodule

// File: design/symmetric_complex_wavelet_power_core.sv
// Top level of the symmetric complex wavelet power core: sequencer, accumulators, output.
// Depends on scwp_pkg, scwp_if, scwp_mul and scwp_store.
//
//   channel  | dir | handshake     | payload
//   item     | in  | valid / ready | op, coef_index, coef_real, coef_imag, sample_value, last
//   result   | out | valid / ready | power, window_error
//   cfg      | in  | cfg_write     | cfg_data -> half_length
//
// Coefficient loads and window samples are written to the store when accepted. After the
// request that carries the last sample the core drops ready and runs its sequencer: a first
// read, a real and an imaginary multiply on the one shared multiplier for each offset
// k = 0..H of a window of 2H+1 samples, rounding, squaring and the final sum. A malformed
// window skips the multiply loop and goes to the finish state. Reset is synchronous and active
// high; it clears the sample count and the output valid and sets half_length to 16. A result
// held by a stalled consumer stays in the output register; the next result waits for it to leave.
module symmetric_complex_wavelet_power_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [scwp_pkg::HALF_LEN_W-1:0] cfg_data,
  scwp_item_if.sink                      item,
  scwp_result_if.source                  result
);
  import scwp_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_RD     = 4'd1;
  localparam logic [ST_W-1:0] S_MRE    = 4'd2;
  localparam logic [ST_W-1:0] S_MIM    = 4'd3;
  localparam logic [ST_W-1:0] S_DRAIN  = 4'd4;
  localparam logic [ST_W-1:0] S_RND_RE = 4'd5;
  localparam logic [ST_W-1:0] S_RND_IM = 4'd6;
  localparam logic [ST_W-1:0] S_SQ_RE  = 4'd7;
  localparam logic [ST_W-1:0] S_SQ_IM  = 4'd8;
  localparam logic [ST_W-1:0] S_SUM    = 4'd9;
  localparam logic [ST_W-1:0] S_FIN    = 4'd10;

  // Round a Q.15 accumulator to nearest, ties toward +infinity, and saturate to signed 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [63:0] q;
    t = v + 64'sd16384;
    q = t >>> 15;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
    end else if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
    end
    return 32'(q);
  endfunction

  logic [ST_W-1:0]       state;
  logic [HALF_LEN_W-1:0] half_length;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_inc;
  logic [HALF_W-1:0]     j;
  logic [HALF_W-1:0]     h;
  logic                  bad_len;

  logic signed [ACC_W-1:0] acc_re;
  logic signed [ACC_W-1:0] acc_im;
  logic signed [31:0]      sr;
  logic signed [31:0]      si;
  logic [63:0]             pw;
  logic [63:0]             sq_sum;
  logic [POWER_W-1:0]      power_pend;
  logic                    err_pend;

  logic                    out_valid;
  logic [POWER_W-1:0]      out_power;
  logic                    out_err;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  store_wr_t   st_wr;
  store_rd_t   st_rd;
  store_data_t st_q;

  logic signed [SAMPLE_BITS:0] pair_sum;
  logic signed [SAMPLE_BITS:0] pair_diff;
  logic [HALF_W-1:0]           j_rd;
  logic                        accept;

  assign h       = HALF_W'(half_length);
  assign accept  = item.valid && item.ready;
  assign cnt_inc = (cnt < CNT_W'(COUNT_SAT)) ? cnt + CNT_W'(1) : cnt;
  assign bad_len = (32'(half_length) > MAX_HALF) ||
                   (32'(cnt_inc) != 32'(half_length) * 2 + 1);

  assign item.ready          = (state == S_IDLE);
  assign result.valid        = out_valid;
  assign result.power        = out_power;
  assign result.window_error = out_err;

  // Store writes come straight from the accepted request.
  always_comb begin
    st_wr.win_we    = accept && (item.op == OP_SAMPLE) && (cnt < CNT_W'(WIN_DEPTH));
    st_wr.win_addr  = cnt[WIN_AW-1:0];
    st_wr.sample    = sample_t'(SAMPLE_BITS'($unsigned(item.sample_value)));
    st_wr.coef_we   = accept && (item.op == OP_LOAD) && (32'(item.coef_index) <= MAX_HALF);
    st_wr.coef_addr = HALF_W'(item.coef_index);
    st_wr.re        = item.coef_real;
    st_wr.im        = item.coef_imag;
  end

  // The read for offset zero is issued in S_RD; the read for j+1 overlaps the second multiply.
  assign j_rd = (state == S_MIM) ? j + HALF_W'(1) : j;
  always_comb begin
    st_rd.en        = (state == S_RD) || ((state == S_MIM) && (j != h));
    st_rd.addr_l    = WIN_AW'(h) - WIN_AW'(j_rd);
    st_rd.addr_r    = WIN_AW'(h) + WIN_AW'(j_rd);
    st_rd.coef_addr = j_rd;
  end

  assign pair_sum  = (SAMPLE_BITS+1)'(st_q.left) + (SAMPLE_BITS+1)'(st_q.right);
  assign pair_diff = (SAMPLE_BITS+1)'(st_q.left) - (SAMPLE_BITS+1)'(st_q.right);

  // Operand selection for the shared multiplier. At offset zero the centre sample stands
  // alone in the real term and the imaginary term is zero.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MRE: begin
        mul_a = (j == '0) ? MUL_W'(st_q.left) : MUL_W'(pair_sum);
        mul_b = MUL_W'(st_q.re);
      end
      S_MIM: begin
        mul_a = (j == '0) ? '0 : MUL_W'(pair_diff);
        mul_b = MUL_W'(st_q.im);
      end
      S_SQ_RE: begin
        mul_a = sr;
        mul_b = sr;
      end
      S_SQ_IM: begin
        mul_a = si;
        mul_b = si;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_sum = pw + $unsigned(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= HALF_LEN_RESET;
    end else if (cfg_write) begin
      half_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // A finished result enters the output register when it is empty or being emptied.
      if ((state == S_FIN) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (item.op == OP_SAMPLE)) begin
            if (item.last) begin
              cnt <= '0;
              state <= bad_len ? S_FIN : S_RD;
            end else begin
              cnt <= cnt_inc;
            end
          end
        end
        S_RD:     state <= S_MRE;
        S_MRE:    state <= S_MIM;
        S_MIM:    state <= (j == h) ? S_DRAIN : S_MRE;
        S_DRAIN:  state <= S_RND_RE;
        S_RND_RE: state <= S_RND_IM;
        S_RND_IM: state <= S_SQ_RE;
        S_SQ_RE:  state <= S_SQ_IM;
        S_SQ_IM:  state <= S_SUM;
        S_SUM:    state <= S_FIN;
        S_FIN: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: offset counter, accumulators, rounded sums, squares, pending and output result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        j      <= '0;
        acc_re <= '0;
        acc_im <= '0;
        power_pend <= '0;
        err_pend   <= bad_len;
      end
      S_MRE: begin
        if (j != '0) begin
          acc_im <= acc_im + ACC_W'(prod);
        end
      end
      S_MIM: begin
        acc_re <= acc_re + ACC_W'(prod);
        j      <= j + HALF_W'(1);
      end
      S_DRAIN:  acc_im <= acc_im + ACC_W'(prod);
      S_RND_RE: sr <= round_sat(64'(acc_re));
      S_RND_IM: si <= round_sat(64'(acc_im));
      S_SQ_IM:  pw <= $unsigned(prod);
      S_SUM:    power_pend <= sq_sum[63] ? {POWER_W{1'b1}} : sq_sum[POWER_W-1:0];
      S_FIN: begin
        if (!out_valid || result.ready) begin
          out_power <= power_pend;
          out_err   <= err_pend;
        end
      end
      default: begin
      end
    endcase
  end

  scwp_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  scwp_store u_store (
    .clk   (clk),
    .wr    (st_wr),
    .rd    (st_rd),
    .rdata (st_q)
  );

  // A request with the last sample always moves the core out of idle, so ready drops next cycle.
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (item.op == OP_SAMPLE) && item.last |=> !item.ready)
    else $error("ready stayed high after the last sample of a window");

  // A malformed window reports zero power.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.window_error |-> (result.power == '0))
    else $error("window error reported with nonzero power");

  // The offset counter never passes the half length during the multiply loop.
  a_j_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MRE || state == S_MIM) |-> (j <= h))
    else $error("offset counter ran past the half length");

  // The sample count saturates and never exceeds its ceiling.
  a_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= COUNT_SAT)
    else $error("sample count passed its saturation value");

endmodule
